### src/png_riff_signature_scanner_assert.svh
// ----------------------------------------------------------------------------
// png_riff_signature_scanner_assert
// assertion macros used only in prss_queue among the scanner modules
// ----------------------------------------------------------------------------
`ifndef PNG_RIFF_SIGNATURE_SCANNER_ASSERT_SVH
`define PNG_RIFF_SIGNATURE_SCANNER_ASSERT_SVH

// condition holds at every edge out of reset
`define PRSS_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PRSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/prss_pkg.sv
// ----------------------------------------------------------------------------
// prss_pkg
// types, signatures and defaults of the png / riff signature scanner
// ----------------------------------------------------------------------------
package prss_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // signature bytes, first byte in the lowest bits
    localparam logic [31:0] PNG_START_SIG = {8'd71, 8'd78, 8'd80, 8'd137};
    localparam logic [63:0] PNG_END_SIG   = {8'd130, 8'd96, 8'd66, 8'd174,
                                             8'd68, 8'd78, 8'd69, 8'd73};
    localparam logic [31:0] RIFF_SIG      = {8'd70, 8'd70, 8'd73, 8'd82};

    localparam logic [3:0] FILL_FULL        = 4'd8;
    localparam logic [3:0] SKIP_PNG_START   = 4'd4;
    localparam logic [3:0] SKIP_PNG_END     = 4'd8;
    localparam logic [3:0] SKIP_RIFF_START  = 4'd12;

    localparam logic [32:0] RIFF_HDR_BYTES  = 33'd8;

    typedef enum logic [1:0] {
        KIND_PNG_START  = 2'd0,
        KIND_PNG_END    = 2'd1,
        KIND_RIFF_START = 2'd2
    } match_kind_t;

    // one classified hit handed from front to back
    typedef struct packed {
        match_kind_t kind;
        logic [32:0] offset;
        logic [31:0] length;
    } hit_t;

endpackage

### src/png_riff_signature_scanner.sv
// ----------------------------------------------------------------------------
// png_riff_signature_scanner
// byte stream scanner that reports png start, png end and riff chunk hits
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while the hit queue has room
// path: a hit goes from the byte window through the queue head register and the output register to m_tvalid
// the hit queue and the output register let input and output stall on their own
// reset: synchronous active-low aresetn clears position, fill, skip and queue
// a byte with s_tlast returns the scan state to its reset values
module png_riff_signature_scanner #(
    parameter int OFFSET_BITS = prss_pkg::OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = prss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [1:0] match_kind, [33:2] match_offset,
                                   // [66:34] audio_end_offset
);

    logic           in_accept;
    logic           hit_valid;
    prss_pkg::hit_t hit_data;
    logic           q_valid;
    logic           q_ready;
    prss_pkg::hit_t q_data;
    logic [1:0]     out_kind;
    logic [31:0]    out_offset;
    logic [32:0]    out_end;
    logic           push_ready;

    assign s_tready  = push_ready;
    assign in_accept = s_tvalid && push_ready;

    prss_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .hit_valid (hit_valid),
        .hit_data  (hit_data)
    );

    prss_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (hit_valid),
        .push_ready (push_ready),
        .push_data  (hit_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    prss_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .hit_valid  (q_valid),
        .hit_ready  (q_ready),
        .hit_data   (q_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_offset (out_offset),
        .out_end    (out_end)
    );

    assign m_tdata = {5'd0, out_end, out_offset, out_kind};

endmodule

### src/prss_front.sv
// ----------------------------------------------------------------------------
// prss_front
// byte window, position and skip tracking; outside a skip classifies each complete window
// ----------------------------------------------------------------------------
module prss_front #(
    parameter int OFFSET_BITS = prss_pkg::OFFSET_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output logic               hit_valid,
    output prss_pkg::hit_t     hit_data
);

    logic [63:0]            window_reg;
    logic [63:0]            window_next;
    logic [3:0]             fill_reg;
    logic [3:0]             fill_next;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic [3:0]             skip_reg;
    logic [3:0]             skip_next;

    logic [OFFSET_BITS-1:0] win_pos;
    logic [OFFSET_BITS+32:0] win_pos_wide;
    logic                   full;
    logic                   is_png_start;
    logic                   is_png_end;
    logic                   is_riff;

    assign window_next  = {in_byte, window_reg[63:8]};
    assign full         = (fill_reg >= (prss_pkg::FILL_FULL - 4'd1));
    assign win_pos      = pos_reg - OFFSET_BITS'(7);
    assign win_pos_wide = {33'd0, win_pos};

    assign is_png_start = (window_next[31:0] == prss_pkg::PNG_START_SIG);
    assign is_png_end   = (window_next == prss_pkg::PNG_END_SIG);
    assign is_riff      = (window_next[31:0] == prss_pkg::RIFF_SIG);

    always_comb begin
        hit_valid       = 1'b0;
        hit_data.kind   = prss_pkg::KIND_PNG_START;
        hit_data.offset = win_pos_wide[32:0];
        hit_data.length = window_next[63:32];
        skip_next       = skip_reg;
        if (in_accept && full) begin
            if (skip_reg != 4'd0) begin
                skip_next = skip_reg - 4'd1;
            end else if (is_png_start) begin
                hit_valid = 1'b1;
                skip_next = prss_pkg::SKIP_PNG_START;
            end else if (is_png_end) begin
                hit_valid     = 1'b1;
                hit_data.kind = prss_pkg::KIND_PNG_END;
                skip_next     = prss_pkg::SKIP_PNG_END;
            end else if (is_riff) begin
                hit_valid     = 1'b1;
                hit_data.kind = prss_pkg::KIND_RIFF_START;
                skip_next     = prss_pkg::SKIP_RIFF_START;
            end
        end
        if (in_accept && in_last) begin
            skip_next = 4'd0;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        pos_next  = pos_reg;
        if (in_accept) begin
            if (in_last) begin
                fill_next = 4'd0;
                pos_next  = '0;
            end else begin
                fill_next = (fill_reg < prss_pkg::FILL_FULL) ? fill_reg + 4'd1 : fill_reg;
                pos_next  = pos_reg + OFFSET_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 4'd0;
            pos_reg  <= '0;
            skip_reg <= 4'd0;
        end else begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
            skip_reg <= skip_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            window_reg <= window_next;
        end
    end

endmodule

### src/prss_queue.sv
// ----------------------------------------------------------------------------
// prss_queue
// short fifo of classified hits between front and back, head held in a register
// ----------------------------------------------------------------------------
`include "png_riff_signature_scanner_assert.svh"

module prss_queue #(
    parameter int QUEUE_DEPTH = prss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  prss_pkg::hit_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output prss_pkg::hit_t pop_data
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(QUEUE_DEPTH);
    localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(QUEUE_DEPTH - 1);

    prss_pkg::hit_t        mem [QUEUE_DEPTH];
    prss_pkg::hit_t        head_data_reg;
    logic                  head_valid_reg;
    logic                  head_valid_next;
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  push;
    logic                  head_free;
    logic                  mem_rd;
    logic                  mem_wr;
    logic                  bypass;
    logic                  head_stall;

    assign push_ready = (count_reg != DEPTH_CNT);
    assign pop_valid  = head_valid_reg;
    assign pop_data   = head_data_reg;
    assign push       = push_valid && push_ready;
    assign head_free  = !head_valid_reg || pop_ready;
    assign mem_rd     = head_free && (count_reg != '0);
    assign bypass     = head_free && (count_reg == '0) && push;
    assign mem_wr     = push && !bypass;
    assign head_stall = head_valid_reg && !pop_ready;

    always_comb begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        count_next      = count_reg;
        head_valid_next = head_valid_reg;
        if (mem_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (mem_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (head_free) begin
            head_valid_next = mem_rd || bypass;
        end
        case ({mem_wr, mem_rd})
            2'b10:   count_next = count_reg + CNT_BITS'(1);
            2'b01:   count_next = count_reg - CNT_BITS'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            head_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            head_valid_reg <= head_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd) begin
            head_data_reg <= mem[rd_ptr_reg];
        end else if (bypass) begin
            head_data_reg <= push_data;
        end
    end

    `PRSS_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= DEPTH_CNT, "queue overfull")
    `PRSS_ASSERT_ALWAYS(a_head_filled, aclk, aresetn, count_reg == '0 || pop_valid, "head idle")
    `PRSS_ASSERT_NEXT(a_head_hold, aclk, aresetn, head_stall, pop_valid, "head dropped")
    `PRSS_ASSERT_NEXT(a_head_data, aclk, aresetn, head_stall, $stable(pop_data), "head changed")

endmodule

### src/prss_back.sv
// ----------------------------------------------------------------------------
// prss_back
// forms the audio end offset and holds the result for the output channel
// ----------------------------------------------------------------------------
module prss_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           hit_valid,
    output logic           hit_ready,
    input  prss_pkg::hit_t hit_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     out_kind,
    output logic [31:0]    out_offset,
    output logic [32:0]    out_end
);

    logic        valid_reg;
    logic        valid_next;
    logic [1:0]  kind_reg;
    logic [31:0] offset_reg;
    logic [32:0] end_reg;
    logic [32:0] end_next;
    logic        load;

    assign hit_ready = !valid_reg || out_ready;
    assign load      = hit_valid && hit_ready;

    always_comb begin
        end_next = 33'd0;
        if (hit_data.kind == prss_pkg::KIND_RIFF_START) begin
            end_next = hit_data.offset + prss_pkg::RIFF_HDR_BYTES + {1'b0, hit_data.length};
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= hit_data.kind;
            offset_reg <= hit_data.offset[31:0];
            end_reg    <= end_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_kind   = kind_reg;
    assign out_offset = offset_reg;
    assign out_end    = end_reg;

endmodule

### verif/tb_png_riff_signature_scanner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_png_riff_signature_scanner
// self-checking bench for the png / riff signature scanner: a queue of byte
// requests feeds a clocked driver, every accepted byte runs through a local
// scan model that queues the hits it should cause, and a clocked monitor
// checks each hit field by field while both sides idle at random
// ----------------------------------------------------------------------------
module tb_png_riff_signature_scanner;

    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 970;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hold_rx;
        logic       wait_drain;
    } byte_req_t;

    typedef struct packed {
        prss_pkg::match_kind_t kind;
        logic [31:0]           offset;
        logic [32:0]           end_off;
    } hit_rec_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] data_byte
    logic        s_tlast  = 1'b0;   // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;           // [1:0] match_kind, [33:2] match_offset,
                                    // [66:34] audio_end_offset

    byte_req_t   byte_reqs [$];
    hit_rec_t    hits_due [$];
    logic [7:0]  file_bytes [$];

    // scan model state
    logic [7:0]  win [8];
    logic [3:0]  fill;
    logic [31:0] scan_pos;
    logic [3:0]  skip;

    int          bad_count = 0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          tx_burst = 0;
    int          rx_burst = 0;
    logic        cur_hold = 1'b0;
    logic        hold_req = 1'b0;
    int          hold_left = 0;

    png_riff_signature_scanner uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic clear_scan();
        for (int i = 0; i < 8; i++) win[i] = 8'd0;
        fill = 4'd0;
        scan_pos = 32'd0;
        skip = 4'd0;
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic last);
        logic [31:0] p;
        logic [31:0] head;
        logic [63:0] whole;
        logic [31:0] len;
        hit_rec_t    hit;
        p = scan_pos - 32'd7;
        for (int i = 0; i < 7; i++) win[i] = win[i+1];
        win[7] = b;
        if (fill < prss_pkg::FILL_FULL) fill = fill + 4'd1;
        scan_pos = scan_pos + 32'd1;
        if (fill >= prss_pkg::FILL_FULL) begin
            head  = {win[3], win[2], win[1], win[0]};
            whole = {win[7], win[6], win[5], win[4], win[3], win[2], win[1], win[0]};
            len   = {win[7], win[6], win[5], win[4]};
            hit.offset  = p;
            hit.end_off = 33'd0;
            if (skip != 4'd0) begin
                skip = skip - 4'd1;
            end else if (head == prss_pkg::PNG_START_SIG) begin
                hit.kind = prss_pkg::KIND_PNG_START;
                hits_due.insert(hits_due.size(), hit);
                skip = prss_pkg::SKIP_PNG_START;
            end else if (whole == prss_pkg::PNG_END_SIG) begin
                hit.kind = prss_pkg::KIND_PNG_END;
                hits_due.insert(hits_due.size(), hit);
                skip = prss_pkg::SKIP_PNG_END;
            end else if (head == prss_pkg::RIFF_SIG) begin
                hit.kind    = prss_pkg::KIND_RIFF_START;
                hit.end_off = {1'b0, p} + prss_pkg::RIFF_HDR_BYTES + {1'b0, len};
                hits_due.insert(hits_due.size(), hit);
                skip = prss_pkg::SKIP_RIFF_START;
            end
        end
        if (last) clear_scan();
    endtask

    task automatic note_bad(input string what, input logic [32:0] want, input logic [32:0] got);
        if (bad_count < MAX_REPORTS)
            $display("mismatch %s: expected %h, got %h", what, want, got);
        bad_count++;
    endtask

    // writes a signature into file_bytes at a position, clipped at the end
    task automatic plant(input int at, input prss_pkg::match_kind_t kind,
                         input logic [31:0] len);
        logic [7:0] sig [8];
        int n;
        n = 4;
        for (int i = 0; i < 4; i++) begin
            sig[i]   = prss_pkg::RIFF_SIG[8*i +: 8];
            sig[i+4] = len[8*i +: 8];
        end
        if (kind == prss_pkg::KIND_PNG_START) begin
            for (int i = 0; i < 4; i++) sig[i] = prss_pkg::PNG_START_SIG[8*i +: 8];
        end else if (kind == prss_pkg::KIND_PNG_END) begin
            for (int i = 0; i < 8; i++) sig[i] = prss_pkg::PNG_END_SIG[8*i +: 8];
            n = 8;
        end else begin
            n = 8;
        end
        for (int i = 0; i < n; i++)
            if (at + i < file_bytes.size()) file_bytes[at+i] = sig[i];
    endtask

    task automatic fill_zero(input int n);
        file_bytes.delete();
        for (int i = 0; i < n; i++) file_bytes.insert(file_bytes.size(), 8'd0);
    endtask

    task automatic push_file(input logic hold, input logic drain);
        byte_req_t req;
        for (int i = 0; i < file_bytes.size(); i++) begin
            req.data       = file_bytes[i];
            req.last       = (i == file_bytes.size() - 1);
            req.hold_rx    = hold && (i == 0);
            req.wait_drain = drain && (i == 0);
            byte_reqs.insert(byte_reqs.size(), req);
        end
    endtask

    // driver: one byte request per handshake
    always @(posedge aclk) begin
        byte_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            s_tlast  <= 1'b0;
            hold_req <= 1'b0;
            clear_scan();
        end else begin
            if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
            hold_req <= s_tvalid && s_tready && cur_hold;
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (byte_reqs.size() == 0 ||
                             (byte_reqs[0].wait_drain && hits_due.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    nxt = byte_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                    cur_hold = nxt.hold_rx;
                    tx_gap = pick_gap(tx_burst);
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        hit_rec_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (hits_due.size() == 0) begin
                    note_bad("unexpected hit", 33'd0, m_tdata[32:0]);
                end else begin
                    want = hits_due.pop_front();
                    if (m_tdata[1:0] != want.kind)
                        note_bad("match_kind", {31'd0, want.kind}, {31'd0, m_tdata[1:0]});
                    if (m_tdata[33:2] != want.offset)
                        note_bad("match_offset", {1'b0, want.offset}, {1'b0, m_tdata[33:2]});
                    if (m_tdata[66:34] != want.end_off)
                        note_bad("audio_end_offset", want.end_off, m_tdata[66:34]);
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready) rx_gap = pick_gap(rx_burst);
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int random_count;
        int flen;
        int at;
        int n_sig;
        int r;
        int k;
        logic [31:0] len;

        // directed: png start, riff with the largest length, iend cut by end of file
        fill_zero(8);
        plant(0, prss_pkg::KIND_PNG_START, 32'd0);
        push_file(1'b0, 1'b0);
        fill_zero(8);
        plant(0, prss_pkg::KIND_RIFF_START, 32'hFFFF_FFFF);
        push_file(1'b0, 1'b0);
        fill_zero(7);
        plant(0, prss_pkg::KIND_PNG_END, 32'd0);
        push_file(1'b0, 1'b0);

        // back-to-back png starts while the receiver holds off
        fill_zero(207);
        for (int i = 0; i < 40; i++) plant(5 * i, prss_pkg::KIND_PNG_START, 32'd0);
        push_file(1'b1, 1'b1);

        random_count = 0;
        while (random_count < RANDOM_BYTES) begin
            flen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 64);
            file_bytes.delete();
            for (int i = 0; i < flen; i++)
                file_bytes.insert(file_bytes.size(), 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) != 0) begin
                n_sig = $urandom_range(1, 4);
                at = $urandom_range(0, 7);
                for (int j = 0; j < n_sig; j++) begin
                    r = $urandom_range(0, 3);
                    len = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
                    plant(at, prss_pkg::match_kind_t'($urandom_range(0, 2)), len);
                    if ($urandom_range(0, 9) == 0) begin
                        k = at + $urandom_range(0, 3);
                        if (k < file_bytes.size())
                            file_bytes[k] = file_bytes[k] ^ (8'd1 << $urandom_range(0, 7));
                    end
                    at = at + $urandom_range(1, 16);
                end
            end
            push_file(1'b0, $urandom_range(0, 19) == 0);
            random_count += flen;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (byte_reqs.size() != 0 || s_tvalid || hits_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        bad_count += hits_due.size();
        if (bad_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
